### sv/md5sh_pkg.sv
// Shared types, constants and round tables for the MD5 stream hasher.
package md5sh_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5sh_abcd_t;

  localparam md5sh_abcd_t MD5SH_INIT = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  localparam int unsigned MD5SH_WORDS = 16;
  localparam logic [3:0]  MD5SH_LAST_ZERO_IDX = 4'd13;
  localparam logic [3:0]  MD5SH_LEN_LO_IDX    = 4'd14;
  localparam logic [3:0]  MD5SH_LEN_HI_IDX    = 4'd15;
  localparam logic [7:0]  MD5SH_PAD_BYTE      = 8'h80;

  localparam logic [31:0] MD5SH_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amount for a round: four values per group of sixteen rounds.
  function automatic logic [4:0] md5sh_rot(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'b0000: s = 5'd7;
      4'b0001: s = 5'd12;
      4'b0010: s = 5'd17;
      4'b0011: s = 5'd22;
      4'b0100: s = 5'd5;
      4'b0101: s = 5'd9;
      4'b0110: s = 5'd14;
      4'b0111: s = 5'd20;
      4'b1000: s = 5'd4;
      4'b1001: s = 5'd11;
      4'b1010: s = 5'd16;
      4'b1011: s = 5'd23;
      4'b1100: s = 5'd6;
      4'b1101: s = 5'd10;
      4'b1110: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index used by a round.
  function automatic logic [3:0] md5sh_widx(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = r;
      2'd1:    g = 4'((r << 2) + r + 4'd1);
      2'd2:    g = 4'((r << 1) + r + 4'd5);
      default: g = 4'((r << 3) - r);
    endcase
    return g;
  endfunction

endpackage

### sv/md5sh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module md5sh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### sv/md5sh_round.sv
// One MD5 round: the shared datapath reused for all 64 rounds of a block.
module md5sh_round
  import md5sh_pkg::*;
(
  input  logic [5:0]  rnd,
  input  md5sh_abcd_t cur,
  input  logic [31:0] w,
  output md5sh_abcd_t nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
    sum = cur.a + f + MD5SH_K[rnd] + w;
    dbl = {sum, sum} << md5sh_rot(rnd);
    nxt.a = cur.d;
    nxt.b = cur.b + dbl[63:32];
    nxt.c = cur.b;
    nxt.d = cur.c;
  end

endmodule

### sv/md5_stream_hasher.sv
// Top level of the MD5 stream hasher: byte intake, padding sequencer and round loop.
//
// The input channel carries one transaction per message byte (in_has_byte high)
// and marks the end of a message with in_end_of_message, on the last byte or
// on an empty transaction. Bytes are gathered into little-endian words and
// written into a 16-word block RAM. A byte transaction that is not the last
// of a block is accepted without a stall.
// When the 64th byte of a block arrives, in_stall stays high while the block
// is compressed: the working words are loaded, then 64 rounds run through the
// single round unit (one round per cycle, message words read from the block
// RAM a round ahead), and the result is added into the chaining words.
// At the end mark the sequencer writes the pad word, zero words and the
// 64-bit bit length, one RAM word per cycle, then compresses; when fewer than
// nine bytes of space remain, two padded blocks are compressed. The digest
// appears on the output channel once the padded block or blocks are compressed,
// and the chaining words and byte count return to their
// initial values. The digest sits in an output register; if the receiver
// stalls it holds, and the block waits before writing a newer digest.
// Reset (synchronous, rst_n low) restores the initial chaining words, clears
// the count and drops out_valid; the block RAM needs no clearing.
module md5_stream_hasher
  import md5sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word0,
  output logic [31:0] out_digest_word1,
  output logic [31:0] out_digest_word2,
  output logic [31:0] out_digest_word3
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PADW,
    S_ZERO,
    S_LEN0,
    S_LEN1,
    S_LOAD,
    S_ROUND,
    S_FIN,
    S_EMIT
  } state_t;

  localparam int AW = $clog2(MD5SH_WORDS);

  state_t      state_r, state_nxt;
  logic [60:0] count_r, count_nxt;
  logic [31:0] word_r, word_nxt;
  logic [3:0]  widx_r, widx_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        end_pend_r, end_pend_nxt;
  logic        need_extra_r, need_extra_nxt;
  logic        last_r, last_nxt;
  md5sh_abcd_t chain_r, chain_nxt;
  md5sh_abcd_t wk_r, wk_nxt;
  md5sh_abcd_t round_out;
  md5sh_abcd_t dig_r, dig_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [1:0]  lane;
  logic [31:0] pad_word;

  assign lane = count_r[1:0];

  // The pad word keeps the bytes already gathered, puts the pad byte in the
  // next lane and zeros the remaining lanes.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < lane) begin
        pad_word[8*k +: 8] = word_r[8*k +: 8];
      end else if (2'(k) == lane) begin
        pad_word[8*k +: 8] = MD5SH_PAD_BYTE;
      end else begin
        pad_word[8*k +: 8] = 8'd0;
      end
    end
  end

  // The read address runs one round ahead so that the registered RAM output
  // lines up with the round that uses it.
  assign ram_raddr = AW'(md5sh_widx((state_r == S_ROUND) ? rnd_r + 6'd1 : 6'd0));

  md5sh_ram #(
    .WIDTH(32),
    .DEPTH(MD5SH_WORDS)
  ) u_blk_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  md5sh_round u_round (
    .rnd(rnd_r),
    .cur(wk_r),
    .w  (ram_rdata),
    .nxt(round_out)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    word_nxt       = word_r;
    widx_nxt       = widx_r;
    rnd_nxt        = rnd_r;
    end_pend_nxt   = end_pend_r;
    need_extra_nxt = need_extra_r;
    last_nxt       = last_r;
    chain_nxt      = chain_r;
    wk_nxt         = wk_r;
    dig_nxt        = dig_r;
    out_valid_nxt  = out_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            word_nxt[8*lane +: 8] = in_data_byte;
            count_nxt = count_r + 61'd1;
            if (lane == 2'd3) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(count_r[5:2]);
              ram_wdata = {in_data_byte, word_r[23:0]};
            end
          end
          if (in_has_byte && count_r[5:0] == 6'd63) begin
            // A full block: compress first, pad afterwards if this ends the message.
            end_pend_nxt = in_end_of_message;
            state_nxt    = S_LOAD;
          end else if (in_end_of_message) begin
            state_nxt = S_PADW;
          end
        end
      end
      S_PADW: begin
        ram_we         = 1'b1;
        ram_waddr      = AW'(count_r[5:2]);
        ram_wdata      = pad_word;
        end_pend_nxt   = 1'b0;
        widx_nxt       = count_r[5:2] + 4'd1;
        need_extra_nxt = (count_r[5:3] == 3'b111);
        if (count_r[5:3] == 3'b111) begin
          // No room for the length: the rest of this block is zero-filled and compressed without it.
          state_nxt = (count_r[5:2] == MD5SH_LEN_HI_IDX) ? S_LOAD : S_ZERO;
        end else begin
          state_nxt = (count_r[5:2] == MD5SH_LAST_ZERO_IDX) ? S_LEN0 : S_ZERO;
        end
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(widx_r);
        ram_wdata = '0;
        widx_nxt  = widx_r + 4'd1;
        if (need_extra_r && widx_r == MD5SH_LEN_HI_IDX) begin
          state_nxt = S_LOAD;
        end else if (!need_extra_r && widx_r == MD5SH_LAST_ZERO_IDX) begin
          state_nxt = S_LEN0;
        end
      end
      S_LEN0: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(MD5SH_LEN_LO_IDX);
        ram_wdata = {count_r[28:0], 3'b000};
        state_nxt = S_LEN1;
      end
      S_LEN1: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(MD5SH_LEN_HI_IDX);
        ram_wdata = count_r[60:29];
        last_nxt  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        wk_nxt    = chain_r;
        rnd_nxt   = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        wk_nxt  = round_out;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        chain_nxt.a = chain_r.a + wk_r.a;
        chain_nxt.b = chain_r.b + wk_r.b;
        chain_nxt.c = chain_r.c + wk_r.c;
        chain_nxt.d = chain_r.d + wk_r.d;
        if (last_r) begin
          state_nxt = S_EMIT;
        end else if (need_extra_r) begin
          need_extra_nxt = 1'b0;
          widx_nxt       = 4'd0;
          state_nxt      = S_ZERO;
        end else if (end_pend_r) begin
          state_nxt = S_PADW;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          dig_nxt       = chain_r;
          out_valid_nxt = 1'b1;
          chain_nxt     = MD5SH_INIT;
          count_nxt     = '0;
          last_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      end_pend_r   <= 1'b0;
      need_extra_r <= 1'b0;
      last_r       <= 1'b0;
      chain_r      <= MD5SH_INIT;
      out_valid_r  <= 1'b0;
      rnd_r        <= '0;
      widx_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      end_pend_r   <= end_pend_nxt;
      need_extra_r <= need_extra_nxt;
      last_r       <= last_nxt;
      chain_r      <= chain_nxt;
      out_valid_r  <= out_valid_nxt;
      rnd_r        <= rnd_nxt;
      widx_r       <= widx_nxt;
      word_r       <= word_nxt;
      wk_r         <= wk_nxt;
      dig_r        <= dig_nxt;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_digest_word0 = dig_r.a;
  assign out_digest_word1 = dig_r.b;
  assign out_digest_word2 = dig_r.c;
  assign out_digest_word3 = dig_r.d;

endmodule

### sv/md5sh_checker.sv
// Port-level checker for the MD5 stream hasher and its bind statement.
module md5sh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word0,
  input logic [31:0] out_digest_word1,
  input logic [31:0] out_digest_word2,
  input logic [31:0] out_digest_word3
);

  // A stalled digest stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word0)
      && $stable(out_digest_word1) && $stable(out_digest_word2)
      && $stable(out_digest_word3))
    else $error("digest changed while stalled");

  // Reset leaves no digest pending.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // An end transaction starts padding or compresses a just-filled block, so the input side stalls next.
  a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_message |=> in_stall)
    else $error("no stall after end of message");

  // A new digest only appears while the input side is busy finishing it.
  a_digest_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("digest appeared without a finishing pass");

endmodule

bind md5_stream_hasher md5sh_checker u_md5sh_checker (.*);

### bench/tb_md5_stream_hasher.sv
// Self-checking testbench for md5_stream_hasher: byte messages in, predicted digests checked out.
module tb_md5_stream_hasher;

  // A digest as the block presents it: word0 is chaining word A, word3 is D.
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } digest_t;

  // The run stops with a failure if it is still going when this limit is reached.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Wait after the last owed digest, in case a late, unexpected digest shows up.
  localparam int unsigned DRAIN_CYCLES = 200;

  // Chaining values that every message starts from.
  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Left-rotate amounts: four per group of sixteen rounds.
  localparam int unsigned SHIFT_TBL [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Additive constant of each of the 64 rounds.
  localparam logic [31:0] ROUND_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word0;
  logic [31:0] out_digest_word1;
  logic [31:0] out_digest_word2;
  logic [31:0] out_digest_word3;

  // Shadow copy of the hasher state, advanced once per accepted transaction.
  logic [31:0] chain_q [4];
  logic [7:0]  msg_block [64];
  logic [60:0] msg_bytes;

  // Digests that the block still owes, oldest first.
  digest_t     digest_q [$];

  // Idle and stall probabilities in percent, changed from phase to phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned n_items = 0;
  int unsigned n_messages = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;

  md5_stream_hasher u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word0  (out_digest_word0),
    .out_digest_word1  (out_digest_word1),
    .out_digest_word2  (out_digest_word2),
    .out_digest_word3  (out_digest_word3)
  );

  always #2 clk = ~clk;

  // Put the chaining words and the byte count back to their start values.
  function automatic void restart_chain();
    for (int k = 0; k < 4; k++) chain_q[k] = CHAIN_INIT[k];
    msg_bytes = '0;
  endfunction

  // Run the 64-round compression over the shadow block and fold the result
  // into the chaining words. The block is read as sixteen little-endian words.
  function automatic void md5_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int unsigned g, sh;
    for (int k = 0; k < 16; k++)
      w[k] = {msg_block[4*k+3], msg_block[4*k+2], msg_block[4*k+1], msg_block[4*k]};
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d);
        g = r;
      end else if (r < 32) begin
        f = (b & d) | (c & ~d);
        g = (5 * r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d;
        g = (3 * r + 5) % 16;
      end else begin
        f = c ^ (b | ~d);
        g = (7 * r) % 16;
      end
      sh  = SHIFT_TBL[(r / 16) * 4 + (r % 4)];
      sum = a + f + ROUND_ADD[r] + w[g];
      t = d;
      d = c;
      c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = t;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
  endfunction

  // Advance the shadow state by one accepted transaction. A byte is appended
  // first; an end mark then pads the message, appends its bit length and
  // queues the digest the block must produce.
  function automatic void absorb_item(input logic [7:0] data, input logic has,
                                      input logic eom);
    int unsigned pos;
    logic [63:0] bit_len;
    if (has) begin
      pos = msg_bytes[5:0];
      msg_block[pos] = data;
      msg_bytes = msg_bytes + 1'b1;
      if (pos == 63) md5_compress();
    end
    if (eom) begin
      pos = msg_bytes[5:0];
      msg_block[pos] = 8'h80;
      for (int k = pos + 1; k < 64; k++) msg_block[k] = 8'h00;
      // Fewer than eight bytes left for the length: close this block and
      // put the length into a fresh block of zeros.
      if (pos >= 56) begin
        md5_compress();
        for (int k = 0; k < 56; k++) msg_block[k] = 8'h00;
      end
      bit_len = {msg_bytes, 3'b000};
      for (int k = 0; k < 8; k++) msg_block[56 + k] = bit_len[8*k +: 8];
      md5_compress();
      digest_q.push_back({chain_q[0], chain_q[1], chain_q[2], chain_q[3]});
      n_messages++;
      restart_chain();
    end
  endfunction

  // Offer one transaction, after a random number of idle cycles, and hold it
  // until the block takes it. The prediction is made at the accepting edge.
  // The stall read right after the edge is the value the edge saw, since the
  // block updates it only in the nonblocking region.
  task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_has_byte       <= has;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    absorb_item(data, has, eom);
    if (has || eom) n_items++;
  endtask

  // One message of random bytes. Ignored transactions (no byte, no end) are
  // sprinkled in at the given rate. The end mark rides on the last byte,
  // or on an empty transaction of its own.
  task automatic send_message(input int unsigned len, input bit empty_end,
                              input int unsigned noise_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !empty_end);
    end
    if (empty_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Random messages until both the transaction and the digest goals are met.
  // Most lengths are short; about a third sit on the padding boundaries of
  // the first two blocks, where one or two padded blocks are needed; a few
  // span up to four blocks.
  task automatic run_random_messages(input int unsigned item_goal,
                                     input int unsigned digest_goal);
    int unsigned items_base, msgs_base, len, sel;
    bit empty_end;
    items_base = n_items;
    msgs_base  = n_messages;
    while (n_items - items_base < item_goal || n_messages - msgs_base < digest_goal) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        len = $urandom_range(40);
      end else if (sel < 87) begin
        len = 64 * $urandom_range(1);
        case ($urandom_range(6))
          0: len += 55;
          1: len += 56;
          2: len += 57;
          3: len += 62;
          4: len += 63;
          5: len += 64;
          default: len += 65;
        endcase
      end else begin
        len = $urandom_range(200, 130);
      end
      empty_end = (len == 0) || ($urandom_range(99) < 30);
      send_message(len, empty_end, ($urandom_range(3) == 0) ? 10 : 0);
      // Now and then a stray ignored transaction between messages.
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  // Hand-picked messages: the empty message, ignored transactions alone and
  // inside a message, the end mark on a byte and on an empty transaction,
  // the extreme byte values, and back-to-back end marks.
  task automatic test_directed_cases();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
  endtask

  // The sender rarely idles while the receiver stalls most of the time, so
  // finished digests back up in the output register.
  task automatic test_stalled_receiver();
    send_idle_pct  = 13;
    recv_stall_pct = 69;
    run_random_messages(560, 8);
  endtask

  // The sender idles most of the time, so gaps land inside blocks, on block
  // boundaries and around the padding sequence.
  task automatic test_idle_sender();
    send_idle_pct  = 69;
    recv_stall_pct = 13;
    run_random_messages(560, 8);
  endtask

  // Back-to-back transactions with the receiver always ready.
  task automatic test_full_rate();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_messages(560, 8);
  endtask

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Every accepted digest is compared, word by word, with the oldest one owed.
  always @(posedge clk) begin
    digest_t exp_digest;
    digest_t got_digest;
    if (rst_n && out_valid && !out_stall) begin
      got_digest = {out_digest_word0, out_digest_word1, out_digest_word2, out_digest_word3};
      if (digest_q.size() == 0) begin
        $error("unexpected digest %h", got_digest);
        n_errors++;
      end else begin
        exp_digest = digest_q.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got_digest[127 - 32*k -: 32] !== exp_digest[127 - 32*k -: 32]) begin
            $error("digest_word%0d: expected %h, got %h", k,
                   exp_digest[127 - 32*k -: 32], got_digest[127 - 32*k -: 32]);
            n_errors++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("tb_md5_stream_hasher: done, errors");
      $finish;
    end
  end

  initial begin
    restart_chain();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 13;
    recv_stall_pct = 69;
    test_directed_cases();
    test_stalled_receiver();
    test_idle_sender();
    test_full_rate();

    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    // Give a late, unexpected digest time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("tb_md5_stream_hasher: done, clean");
    end else begin
      $display("tb_md5_stream_hasher: done, errors");
    end
    $finish;
  end

endmodule
